[rtl/core/sbr_hbg_pkg.sv]
// Shared types, constants and helpers of the SBR high-band generator.
// Used by the coefficient unit, the tap cells, the output queue and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbr_hbg_pkg;

    localparam int unsigned SMP_W      = 32;  // sample and coefficient width
    localparam int unsigned BW_W       = 31;  // bandwidth factor width
    localparam int unsigned ACC_W      = 61;  // accumulator bits kept (bits 60:29 form the result)
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned OUT_DEPTH  = 8;   // output queue words

    localparam logic [SMP_W-1:0] UNITY_Q29 = 32'h2000_0000;
    localparam logic [ACC_W-1:0] ROUND_Q29 = 61'h0000_0000_1000_0000;
    localparam logic [63:0]      HALF_Q31  = 64'h0000_0000_4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA0_RE = 3'd0,
        REG_ALPHA0_IM = 3'd1,
        REG_ALPHA1_RE = 3'd2,
        REG_ALPHA1_IM = 3'd3,
        REG_BANDWIDTH = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } t_cplx;

    // token handed from cell to cell: one accepted word
    typedef struct packed {
        logic  valid;
        logic  keep;   // word produces a result
        t_cplx smp;
    } t_token;

    // partial sum handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             keep;
        logic [ACC_W-1:0] re;
        logic [ACC_W-1:0] im;
    } t_sum;

    typedef struct packed {
        t_cplx c1;   // first-order, alpha0 * bw
        t_cplx c2;   // second-order, alpha1 * bw^2
    } t_coefs;

    // Q31 rounding of a wrapped 64-bit product, low 32 bits kept
    function automatic logic [SMP_W-1:0] round_q31(input logic [63:0] p);
        logic [63:0] s;
        s = p + HALF_Q31;
        return s[62:31];
    endfunction

endpackage

`default_nettype wire

[rtl/core/sbr_hbg_coef.sv]
// Configuration registers and coefficient scaling.
// Depends on sbr_hbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbr_hbg_coef import sbr_hbg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_coefs                     o_coefs,
    output logic                       o_busy
);

    logic signed [SMP_W-1:0] r_a0_re, r_a0_im, r_a1_re, r_a1_im;
    logic [BW_W-1:0]         r_bw;
    logic [SMP_W-1:0]        r_bw2;
    t_coefs                  r_coefs;
    logic                    r_busy_a, r_busy_b;
    logic                    w_idx_ok;

    logic signed [SMP_W-1:0] w_bw_s;
    logic signed [63:0]      w_m_bw2, w_m_c1re, w_m_c1im, w_m_c2re, w_m_c2im;

    assign w_idx_ok = i_cfg_idx <= REG_BANDWIDTH;
    assign w_bw_s   = {1'b0, r_bw};

    always_comb begin
        w_m_bw2  = w_bw_s * w_bw_s;
        w_m_c1re = r_a0_re * w_bw_s;
        w_m_c1im = r_a0_im * w_bw_s;
        w_m_c2re = r_a1_re * $signed(r_bw2);
        w_m_c2im = r_a1_im * $signed(r_bw2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0_re  <= '0;
            r_a0_im  <= '0;
            r_a1_re  <= '0;
            r_a1_im  <= '0;
            r_bw     <= '0;
            r_bw2    <= '0;
            r_coefs  <= '0;
            r_busy_a <= 1'b0;
            r_busy_b <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_ALPHA0_RE: r_a0_re <= i_cfg_data;
                    REG_ALPHA0_IM: r_a0_im <= i_cfg_data;
                    REG_ALPHA1_RE: r_a1_re <= i_cfg_data;
                    REG_ALPHA1_IM: r_a1_im <= i_cfg_data;
                    REG_BANDWIDTH: r_bw    <= i_cfg_data[BW_W-1:0];
                    default: ;
                endcase
            end
            r_busy_a <= i_cfg_we && w_idx_ok;
            r_busy_b <= r_busy_a;
            // step one: bw^2 and first-order terms
            if (r_busy_a) begin
                r_bw2        <= round_q31(w_m_bw2);
                r_coefs.c1.re <= round_q31(w_m_c1re);
                r_coefs.c1.im <= round_q31(w_m_c1im);
            end
            // step two: second-order terms use the fresh bw^2
            if (r_busy_b) begin
                r_coefs.c2.re <= round_q31(w_m_c2re);
                r_coefs.c2.im <= round_q31(w_m_c2im);
            end
        end
    end

    assign o_coefs = r_coefs;
    assign o_busy  = r_busy_a || r_busy_b;

endmodule

`default_nettype wire

[rtl/core/sbr_hbg_cell.sv]
// One tap cell: holds one history sample, multiplies the arriving sample
// by its coefficient and adds the term to the neighbor's partial sum.
// Depends on sbr_hbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbr_hbg_cell import sbr_hbg_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_token i_tok,
    input  wire t_cplx  i_coef,
    input  wire t_sum   i_sum,
    output t_token      o_tok,
    output t_sum        o_sum
);

    t_cplx            r_hist;
    logic             r_tok_valid, r_tok_keep;
    t_cplx            r_tok_smp;
    logic             r_v1, r_k1, r_v2, r_k2, r_v3, r_k3;
    logic [ACC_W-1:0] r_rr, r_ii, r_ri, r_ir;
    logic [ACC_W-1:0] r_t_re, r_t_im, r_s_re, r_s_im;
    logic signed [63:0] w_rr, w_ii, w_ri, w_ir;

    always_comb begin
        w_rr = i_tok.smp.re * i_coef.re;
        w_ii = i_tok.smp.im * i_coef.im;
        w_ri = i_tok.smp.re * i_coef.im;
        w_ir = i_tok.smp.im * i_coef.re;
    end

    // control and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_tok_valid <= 1'b0;
            r_tok_keep  <= 1'b0;
            r_v1        <= 1'b0;
            r_k1        <= 1'b0;
            r_v2        <= 1'b0;
            r_k2        <= 1'b0;
            r_v3        <= 1'b0;
            r_k3        <= 1'b0;
        end else begin
            r_tok_valid <= i_tok.valid;
            if (i_tok.valid) begin
                r_hist     <= i_tok.smp;
                r_tok_keep <= i_tok.keep;
            end
            r_v1 <= i_tok.valid;
            r_k1 <= i_tok.keep;
            r_v2 <= r_v1;
            r_k2 <= r_k1;
            r_v3 <= r_v2;
            r_k3 <= r_k2;
        end
    end

    // datapath: product, complex term, partial sum
    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_tok_smp <= r_hist;   // older sample moves on to the neighbor
        end
        r_rr   <= w_rr[ACC_W-1:0];
        r_ii   <= w_ii[ACC_W-1:0];
        r_ri   <= w_ri[ACC_W-1:0];
        r_ir   <= w_ir[ACC_W-1:0];
        r_t_re <= r_rr - r_ii;
        r_t_im <= r_ri + r_ir;
        r_s_re <= r_t_re + i_sum.re;
        r_s_im <= r_t_im + i_sum.im;
    end

    assign o_tok = '{valid: r_tok_valid, keep: r_tok_keep, smp: r_tok_smp};
    assign o_sum = '{valid: r_v3, keep: r_k3, re: r_s_re, im: r_s_im};

endmodule

`default_nettype wire

[rtl/core/sbr_hbg_queue.sv]
// Output queue with credit count covering words still in the cell chain.
// Depends on sbr_hbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbr_hbg_queue import sbr_hbg_pkg::*; #(
    parameter int unsigned P_DEPTH = OUT_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_reserve,   // result-bearing word accepted at input
    input  wire logic  i_push,
    input  wire t_cplx i_data,
    input  wire logic  i_pop,
    output logic       o_room,
    output logic       o_valid,
    output t_cplx      o_data
);

    localparam int unsigned PW = $clog2(P_DEPTH);
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    t_cplx           r_mem [P_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt, r_credit;
    logic [CW-1:0]   n_cnt, n_credit;
    logic            w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    always_comb begin
        n_cnt    = r_cnt;
        n_credit = r_credit;
        case ({i_push, w_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
        case ({i_reserve, w_pop})
            2'b10:   n_credit = r_credit + CW'(1);
            2'b01:   n_credit = r_credit - CW'(1);
            default: n_credit = r_credit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_cnt    <= '0;
            r_credit <= '0;
        end else begin
            r_cnt    <= n_cnt;
            r_credit <= n_credit;
            if (i_push) begin
                r_wr <= (r_wr == PW'(P_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(P_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_room  = r_credit < CW'(P_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

endmodule

`default_nettype wire

[rtl/core/sbr_high_band_generator_unit.sv]
// Top level of the SBR high-band generator: complex second-order predictor.
// Depends on sbr_hbg_pkg, sbr_hbg_coef, sbr_hbg_cell and sbr_hbg_queue.
//
//   channel   direction  handshake            payload
//   ------------------------------------------------------------------------
//   input     in         i_valid / o_ready    i_sample_re, i_sample_im,
//                                             i_history_only
//   output    out        o_valid / i_ready    o_high_re, o_high_im
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One word is taken per cycle while o_ready is high. A result word passes
// the three-cell chain (product, complex term and partial sum stages, one
// cell per tap) and is written to the output queue.
// A register write to a used index holds o_ready low during coefficient scaling.
// Reset (synchronous, active low) clears history, registers and coefficients.
// Output stalls fill an 8-word queue; besides coefficient scaling, o_ready drops
// only when every queue slot is claimed by a stored or in-flight result word.
`timescale 1ns / 1ps
`default_nettype none

module sbr_high_band_generator_unit import sbr_hbg_pkg::*; #(
    parameter int unsigned P_OUT_DEPTH = OUT_DEPTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    // input words
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [SMP_W-1:0] i_sample_re,
    input  wire logic signed [SMP_W-1:0] i_sample_im,
    input  wire logic                    i_history_only,
    // result words
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [SMP_W-1:0]      o_high_re,
    output logic signed [SMP_W-1:0]      o_high_im
);

    t_coefs w_coefs;
    logic   w_busy;
    logic   w_room;
    logic   w_accept;
    t_token w_tok0, w_tok1, w_tok2;
    t_sum   w_sum_init, w_sum0, w_sum1, w_sum2;
    t_cplx  w_unity;
    t_cplx  w_res;
    t_cplx  w_out;

    // Coefficient scaling after every write to a used register index
    sbr_hbg_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (w_coefs),
        .o_busy     (w_busy)
    );

    assign o_ready  = !w_busy && w_room;
    assign w_accept = i_valid && o_ready;

    // Token entering the chain; history-only words shift history but give no result
    assign w_tok0 = '{valid: w_accept, keep: !i_history_only,
                      smp: '{re: i_sample_re, im: i_sample_im}};

    // Rounding constant seeds the partial sum at the head of the chain
    assign w_sum_init = '{valid: 1'b0, keep: 1'b0, re: ROUND_Q29, im: ROUND_Q29};

    // Current sample is weighted by 2^29
    assign w_unity = '{re: UNITY_Q29, im: '0};

    // Cell 0: current sample. Cell 1: one word back. Cell 2: two words back.
    // Each cell passes its held sample to the next as a new word arrives.
    sbr_hbg_cell u_cell0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok0),
        .i_coef  (w_unity),
        .i_sum   (w_sum_init),
        .o_tok   (w_tok1),
        .o_sum   (w_sum0)
    );

    sbr_hbg_cell u_cell1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok1),
        .i_coef  (w_coefs.c1),
        .i_sum   (w_sum0),
        .o_tok   (w_tok2),
        .o_sum   (w_sum1)
    );

    sbr_hbg_cell u_cell2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok2),
        .i_coef  (w_coefs.c2),
        .i_sum   (w_sum1),
        .o_tok   (),
        .o_sum   (w_sum2)
    );

    // Result is bits 60:29 of the rounded accumulator (wraps naturally)
    assign w_res = '{re: w_sum2.re[ACC_W-1:ACC_W-SMP_W], im: w_sum2.im[ACC_W-1:ACC_W-SMP_W]};

    sbr_hbg_queue #(
        .P_DEPTH (P_OUT_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (w_accept && !i_history_only),
        .i_push    (w_sum2.valid && w_sum2.keep),
        .i_data    (w_res),
        .i_pop     (i_ready),
        .o_room    (w_room),
        .o_valid   (o_valid),
        .o_data    (w_out)
    );

    assign o_high_re = w_out.re;
    assign o_high_im = w_out.im;

endmodule

`default_nettype wire

[sim/sbr_hbg_checker.sv]
// Checker for the SBR high-band generator: mirrors the registers, predicts each result word.
// Compares result words in order. Depends on sbr_hbg_pkg only.
`timescale 1ns / 1ps

module sbr_hbg_checker import sbr_hbg_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_ready,
    input  wire logic signed [SMP_W-1:0] i_sample_re,
    input  wire logic signed [SMP_W-1:0] i_sample_im,
    input  wire logic                    i_history_only,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_ready,
    input  wire logic signed [SMP_W-1:0] i_high_re,
    input  wire logic signed [SMP_W-1:0] i_high_im,
    output int                           o_pending,
    output int                           o_mismatches
);

    localparam logic [63:0] Q31_HALF = 64'h0000_0000_4000_0000;
    localparam logic [63:0] Q29_ONE  = 64'h0000_0000_2000_0000;
    localparam logic [63:0] Q29_HALF = 64'h0000_0000_1000_0000;

    logic [SMP_W-1:0] alpha0_re_q, alpha0_im_q, alpha1_re_q, alpha1_im_q;
    logic [BW_W-1:0]  bw_q;
    t_coefs           coef_q;
    t_cplx            prev1_q, prev2_q;
    t_cplx            high_band_q [$];
    t_cplx            cur, want;
    logic             reg_hit;
    int               mismatch_cnt;

    function automatic logic [63:0] sx64(input logic [SMP_W-1:0] v);
        return {{32{v[SMP_W-1]}}, v};
    endfunction

    // round to nearest, drop 31 fraction bits, keep low 32 bits
    function automatic logic [SMP_W-1:0] q31_round(input logic [63:0] p);
        logic [63:0] s;
        s = (p + Q31_HALF) >> 31;
        return s[SMP_W-1:0];
    endfunction

    function automatic t_coefs scale_coefs(input logic [SMP_W-1:0] a0r, a0i, a1r, a1i,
                                           input logic [BW_W-1:0] bw);
        logic [63:0]      bw64;
        logic [SMP_W-1:0] bw_sq;
        t_coefs           c;
        bw64    = {33'd0, bw};
        bw_sq   = q31_round(bw64 * bw64);
        c.c1.re = q31_round(sx64(a0r) * bw64);
        c.c1.im = q31_round(sx64(a0i) * bw64);
        c.c2.re = q31_round(sx64(a1r) * sx64(bw_sq));
        c.c2.im = q31_round(sx64(a1i) * sx64(bw_sq));
        return c;
    endfunction

    // x*2^29 + c2*x[n-2] + c1*x[n-1], all mod 2^64, then rounded >> 29
    function automatic t_cplx predict_high_band(input t_cplx x, p1, p2, input t_coefs c);
        logic [63:0] acc_re, acc_im;
        t_cplx       y;
        acc_re = sx64(x.re) * Q29_ONE
               + sx64(p2.re) * sx64(c.c2.re) - sx64(p2.im) * sx64(c.c2.im)
               + sx64(p1.re) * sx64(c.c1.re) - sx64(p1.im) * sx64(c.c1.im)
               + Q29_HALF;
        acc_im = sx64(x.im) * Q29_ONE
               + sx64(p2.im) * sx64(c.c2.re) + sx64(p2.re) * sx64(c.c2.im)
               + sx64(p1.im) * sx64(c.c1.re) + sx64(p1.re) * sx64(c.c1.im)
               + Q29_HALF;
        y.re = acc_re[60:29];
        y.im = acc_im[60:29];
        return y;
    endfunction

    initial begin
        mismatch_cnt = 0;
        o_pending    = 0;
        o_mismatches = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alpha0_re_q = '0;
            alpha0_im_q = '0;
            alpha1_re_q = '0;
            alpha1_im_q = '0;
            bw_q        = '0;
            coef_q      = '0;
            prev1_q     = '0;
            prev2_q     = '0;
            high_band_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (high_band_q.size() == 0) begin
                    $error("unexpected result word: high_re %0d high_im %0d",
                           i_high_re, i_high_im);
                    mismatch_cnt++;
                end else begin
                    want = high_band_q.pop_front();
                    if (i_high_re !== want.re) begin
                        $error("high_re: expected %0d, actual %0d", want.re, i_high_re);
                        mismatch_cnt++;
                    end
                    if (i_high_im !== want.im) begin
                        $error("high_im: expected %0d, actual %0d", want.im, i_high_im);
                        mismatch_cnt++;
                    end
                end
            end

            if (i_cfg_we) begin
                reg_hit = 1'b1;
                case (i_cfg_idx)
                    REG_ALPHA0_RE: alpha0_re_q = i_cfg_data;
                    REG_ALPHA0_IM: alpha0_im_q = i_cfg_data;
                    REG_ALPHA1_RE: alpha1_re_q = i_cfg_data;
                    REG_ALPHA1_IM: alpha1_im_q = i_cfg_data;
                    REG_BANDWIDTH: bw_q        = i_cfg_data[BW_W-1:0];
                    default:       reg_hit     = 1'b0;
                endcase
                if (reg_hit)
                    coef_q = scale_coefs(alpha0_re_q, alpha0_im_q, alpha1_re_q, alpha1_im_q,
                                         bw_q);
            end

            if (i_in_valid && i_in_ready) begin
                cur.re = i_sample_re;
                cur.im = i_sample_im;
                if (!i_history_only)
                    high_band_q.push_back(predict_high_band(cur, prev1_q, prev2_q, coef_q));
                prev2_q = prev1_q;
                prev1_q = cur;
            end
        end
        o_pending    <= high_band_q.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

[sim/tb.sv]
// Testbench top for sbr_high_band_generator_unit: clock, reset, stimulus and verdict.
// Depends on sbr_hbg_pkg, the RTL under rtl/core and sim/sbr_hbg_checker.sv.
`timescale 1ns / 1ps

module tb;
    import sbr_hbg_pkg::*;

    localparam logic [SMP_W-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [SMP_W-1:0] S_MIN = 32'h8000_0000;
    localparam logic [SMP_W-1:0] S_ONES = 32'hFFFF_FFFF;

    localparam int PHASE_ITEMS   = 315;   // random words per coefficient setting
    localparam int HOLD_CYCLES   = 80;    // one long output back-pressure stretch
    localparam int SETTLE_CYCLES = 12;    // covers the pipe plus history words
    localparam int DRAIN_CYCLES  = 20;
    localparam int IDLE_PCT      = 32;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [SMP_W-1:0] i_sample_re;
    logic signed [SMP_W-1:0] i_sample_im;
    logic                    i_history_only;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [SMP_W-1:0] o_high_re;
    logic signed [SMP_W-1:0] o_high_im;

    int   pending;
    int   mismatches;
    // both set with nonblocking writes so every process sees them on the same edge
    logic calm     = 1'b0;   // no idling on either side
    logic hold_req = 1'b0;   // ask the receiver for its long hold-off
    logic hold_done;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sbr_high_band_generator_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_re    (i_sample_re),
        .i_sample_im    (i_sample_im),
        .i_history_only (i_history_only),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_high_re      (o_high_re),
        .o_high_im      (o_high_im)
    );

    sbr_hbg_checker u_high_band_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_sample_re    (i_sample_re),
        .i_sample_im    (i_sample_im),
        .i_history_only (i_history_only),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_high_re      (o_high_re),
        .i_high_im      (o_high_im),
        .o_pending      (pending),
        .o_mismatches   (mismatches)
    );

    // Receiver: ready about 68% of cycles, steady in calm phases, and once a long
    // hold-off so the 8-word queue fills and o_ready drops while words keep coming.
    initial begin
        hold_done = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
                @(posedge i_clk);
            end
        end
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Sample values: mostly full-range, some rails, some small magnitudes.
    function automatic logic [SMP_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 12) begin
            case ($urandom_range(3))
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return '0;
                default: return S_ONES;
            endcase
        end
        if (r < 35)
            return 32'($urandom_range(2000) - 1000);
        return $urandom();
    endfunction

    // Offer one word; returns right after the edge that accepts it.
    // An idle gap drops valid first, so valid is only touched once per edge.
    task automatic send_word(input logic [SMP_W-1:0] re, input logic [SMP_W-1:0] im,
                             input logic hist);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_re    <= re;
        i_sample_im    <= im;
        i_history_only <= hist;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Register write; i_cfg_we is lowered again, so back-to-back calls never collide.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes to the unused indexes must leave the coefficients alone.
    task automatic poke_unused_regs();
        for (int k = int'(REG_BANDWIDTH) + 1; k < (1 << CFG_IDX_W); k++)
            cfg_write(k[CFG_IDX_W-1:0], $urandom());
    endtask

    // Let every expected word come out, then give history words time to leave the pipe.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed runs: two history words, then a burst of result words.
    // Some runs have a short or missing preload, and a few history words land mid-burst.
    task automatic stream_runs(input int n_words);
        int sent, lead, burst, roll;
        sent = 0;
        while (sent < n_words) begin
            roll  = $urandom_range(99);
            lead  = (roll < 80) ? 2 : ((roll < 90) ? 1 : 0);
            burst = $urandom_range(12, 1);
            repeat (lead) begin
                send_word(pick_sample(), pick_sample(), 1'b1);
                sent++;
            end
            repeat (burst) begin
                send_word(pick_sample(), pick_sample(), $urandom_range(99) < 5);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= '0;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_sample_re    <= '0;
        i_sample_im    <= '0;
        i_history_only <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients are zero and the history still holds zeros:
        // every result, also before two samples, is just the rounded current sample.
        send_word(S_MAX, S_MIN, 1'b0);
        send_word(S_MIN, S_MAX, 1'b0);
        send_word('0, S_ONES, 1'b1);
        send_word(S_ONES, '0, 1'b0);
        wait_idle();

        // Rail coefficients with full bandwidth; bit 31 of the bandwidth write is dropped.
        cfg_write(REG_ALPHA0_RE, S_MAX);
        cfg_write(REG_ALPHA0_IM, S_MIN);
        cfg_write(REG_ALPHA1_RE, S_MIN);
        cfg_write(REG_ALPHA1_IM, S_MAX);
        cfg_write(REG_BANDWIDTH, S_ONES);
        poke_unused_regs();

        // Rail samples against rail coefficients: the accumulator wraps.
        send_word(S_MAX, S_MAX, 1'b1);
        send_word(S_MIN, S_MIN, 1'b1);
        send_word(S_MAX, S_MIN, 1'b0);
        send_word(S_MIN, S_MAX, 1'b0);
        send_word('0, '0, 1'b0);
        send_word(S_MAX, S_MAX, 1'b0);
        send_word(S_MIN, S_MIN, 1'b0);
        send_word(S_ONES, 32'd1, 1'b0);
        send_word(S_MIN, S_MIN, 1'b0);

        // First random phase carries the long receiver hold-off.
        hold_req <= 1'b1;
        stream_runs(PHASE_ITEMS);

        for (int ph = 1; ph < 6; ph++) begin
            wait_idle();
            calm <= (ph == 3);
            case (ph)
                1: begin
                    // most negative coefficients, full bandwidth
                    cfg_write(REG_ALPHA0_RE, S_MIN);
                    cfg_write(REG_ALPHA0_IM, S_MIN);
                    cfg_write(REG_ALPHA1_RE, S_MIN);
                    cfg_write(REG_ALPHA1_IM, S_MIN);
                    cfg_write(REG_BANDWIDTH, {1'b0, S_MAX[BW_W-1:0]});
                end
                2: begin
                    // zero bandwidth kills both prediction terms
                    cfg_write(REG_ALPHA0_RE, $urandom());
                    cfg_write(REG_ALPHA0_IM, $urandom());
                    cfg_write(REG_ALPHA1_RE, $urandom());
                    cfg_write(REG_ALPHA1_IM, $urandom());
                    cfg_write(REG_BANDWIDTH, '0);
                end
                3: begin
                    cfg_write(REG_BANDWIDTH, $urandom());
                    cfg_write(REG_ALPHA0_RE, $urandom());
                    cfg_write(REG_ALPHA0_IM, $urandom());
                    cfg_write(REG_ALPHA1_RE, $urandom());
                    cfg_write(REG_ALPHA1_IM, $urandom());
                end
                4: begin
                    // a lone bandwidth write must rescale all four coefficients
                    cfg_write(REG_BANDWIDTH, $urandom());
                end
                default: begin
                    cfg_write(REG_ALPHA0_RE, S_MAX);
                    cfg_write(REG_ALPHA0_IM, S_MAX);
                    cfg_write(REG_ALPHA1_RE, S_MAX);
                    cfg_write(REG_ALPHA1_IM, S_MAX);
                    cfg_write(REG_BANDWIDTH, $urandom());
                    poke_unused_regs();
                end
            endcase
            stream_runs(PHASE_ITEMS);
        end

        calm <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
